// File: rtl/core/fss_pkg.sv
// Shared types and constants for the fuzzy sub-image search unit.
// No dependencies; used by fss_divider, fss_engine and the top level.
package fss_pkg;

   localparam int DIM_W     = 9;
   localparam int ADDR_W    = 16;
   localparam int PIX_W     = 8;
   localparam int OP_W      = 2;
   localparam int CNT_W     = 4;
   localparam int REG_IDX_W = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(DIM_W - 1);

   localparam logic [OP_W-1:0] OP_LOAD_MAIN = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_TMPL = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH    = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_MAIN_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MAIN_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TMPL_WIDTH  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TMPL_HEIGHT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TOLERANCE   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DIVISOR     = 3'd5;

   localparam logic [DIM_W-1:0] RST_MAIN_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0] RST_MAIN_HEIGHT = 9'd256;
   localparam logic [DIM_W-1:0] RST_TMPL_WIDTH  = 9'd1;
   localparam logic [DIM_W-1:0] RST_TMPL_HEIGHT = 9'd1;
   localparam logic [DIM_W-1:0] RST_TOLERANCE   = 9'd24;
   localparam logic [DIM_W-1:0] RST_DIVISOR     = 9'd10;

   typedef struct packed {
      logic [DIM_W-1:0] main_width;
      logic [DIM_W-1:0] main_height;
      logic [DIM_W-1:0] tmpl_width;
      logic [DIM_W-1:0] tmpl_height;
      logic [DIM_W-1:0] tolerance;
      logic [DIM_W-1:0] mismatch_divisor;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic found;
   } result_type;

endpackage

// File: rtl/core/fss_divider.sv
// Restoring divider, one quotient bit per cycle, for the row mismatch limit.
// Depends on fss_pkg.
module fss_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [fss_pkg::DIM_W-1:0] dividend,
   input  logic [fss_pkg::DIM_W-1:0] divisor,
   output logic                      done,
   output logic [fss_pkg::DIM_W-1:0] quotient
);

   logic                      busy_ff;
   logic                      done_ff;
   logic [fss_pkg::CNT_W-1:0] cnt_ff;
   logic [fss_pkg::DIM_W-1:0] rem_ff;
   logic [fss_pkg::DIM_W-1:0] quo_ff;
   logic [fss_pkg::DIM_W-1:0] dsr_ff;

   logic [fss_pkg::DIM_W:0]   shifted;
   logic [fss_pkg::DIM_W+1:0] diff;
   logic                      ge;
   logic [fss_pkg::DIM_W-1:0] rem_in;
   logic [fss_pkg::DIM_W-1:0] quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[fss_pkg::DIM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      ge      = ~diff[fss_pkg::DIM_W+1];
      rem_in  = ge ? diff[fss_pkg::DIM_W-1:0] : shifted[fss_pkg::DIM_W-1:0];
      quo_in  = {quo_ff[fss_pkg::DIM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == fss_pkg::DIV_LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/fss_engine.sv
// Pixel stores and search sequencer: loads write the stores, a search walks the
// placements until one matches, with one read per store per compared pixel. Depends on fss_pkg, fss_divider.
module fss_engine #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fss_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [fss_pkg::OP_W-1:0]   req_op,
   input  logic [fss_pkg::ADDR_W-1:0] req_index,
   input  logic [fss_pkg::PIX_W-1:0]  req_value,
   output fss_pkg::result_type        res,
   input  logic                       res_ready
);

   localparam int DW = fss_pkg::DIM_W;
   localparam int AW = fss_pkg::ADDR_W;
   localparam int PW = fss_pkg::PIX_W;
   localparam int DEPTH = 2 ** AW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FETCH,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [PW-1:0] main_mem [DEPTH];
   logic [PW-1:0] tmpl_mem [DEPTH];
   logic [PW-1:0] main_q_ff;
   logic [PW-1:0] tmpl_q_ff;

   logic [DW-1:0] mw_ff, mh_ff, tw_ff, th_ff, tol_ff;
   logic [DW-1:0] xlast_ff, ylast_ff;
   logic [DW-1:0] x_ff, y_ff, r_ff, i_ff, miss_ff;
   logic [AW-1:0] yrow_ff, pbase_ff, rstart_ff, mptr_ff, tptr_ff;
   logic          found_ff;

   logic [DW-1:0] mw_c, mh_c, tw_c, th_c, div_c;
   logic          accept, search_go;
   logic          div_done;
   logic [DW-1:0] limit;

   logic [PW-1:0] adiff;
   logic          mis;
   logic [DW-1:0] miss_next;
   logic          row_fail, last_pix, last_row, last_x, last_y;
   logic [AW-1:0] pbase_next_x, yrow_next, rstart_next;

   always_comb begin
      mw_c = (cfg.main_width == '0) ? DW'(1) :
             (int'(cfg.main_width) > MAX_WIDTH) ? DW'(MAX_WIDTH) : cfg.main_width;
      mh_c = (cfg.main_height == '0) ? DW'(1) :
             (int'(cfg.main_height) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : cfg.main_height;
      tw_c = (cfg.tmpl_width == '0) ? DW'(1) :
             (int'(cfg.tmpl_width) > MAX_WIDTH) ? DW'(MAX_WIDTH) : cfg.tmpl_width;
      th_c = (cfg.tmpl_height == '0) ? DW'(1) :
             (int'(cfg.tmpl_height) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : cfg.tmpl_height;
      div_c = (cfg.mismatch_divisor == '0) ? DW'(1) : cfg.mismatch_divisor;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign search_go = accept && (req_op == fss_pkg::OP_SEARCH);

   fss_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (search_go),
      .dividend (tw_c),
      .divisor  (div_c),
      .done     (div_done),
      .quotient (limit)
   );

   always_ff @(posedge clock) begin
      if (accept && (req_op == fss_pkg::OP_LOAD_MAIN)) begin
         main_mem[req_index] <= req_value;
      end
      main_q_ff <= main_mem[mptr_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && (req_op == fss_pkg::OP_LOAD_TMPL)) begin
         tmpl_mem[req_index] <= req_value;
      end
      tmpl_q_ff <= tmpl_mem[tptr_ff];
   end

   always_comb begin
      adiff        = (main_q_ff > tmpl_q_ff) ? (main_q_ff - tmpl_q_ff)
                                             : (tmpl_q_ff - main_q_ff);
      mis          = ({1'b0, adiff} >= tol_ff);
      miss_next    = miss_ff + DW'(mis);
      row_fail     = mis && (miss_next > limit);
      last_pix     = (i_ff == tw_ff - 1'b1);
      last_row     = (r_ff == th_ff - 1'b1);
      last_x       = (x_ff == xlast_ff);
      last_y       = (y_ff == ylast_ff);
      pbase_next_x = pbase_ff + 1'b1;
      yrow_next    = yrow_ff + AW'(mw_ff);
      rstart_next  = rstart_ff + AW'(mw_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (search_go) begin
                  mw_ff    <= mw_c;
                  mh_ff    <= mh_c;
                  tw_ff    <= tw_c;
                  th_ff    <= th_c;
                  tol_ff   <= cfg.tolerance;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  if ((tw_ff > mw_ff) || (th_ff > mh_ff)) begin
                     found_ff <= 1'b0;
                     state_ff <= ST_DONE;
                  end else begin
                     xlast_ff  <= mw_ff - tw_ff;
                     ylast_ff  <= mh_ff - th_ff;
                     x_ff      <= '0;
                     y_ff      <= '0;
                     r_ff      <= '0;
                     i_ff      <= '0;
                     miss_ff   <= '0;
                     yrow_ff   <= '0;
                     pbase_ff  <= '0;
                     rstart_ff <= '0;
                     mptr_ff   <= '0;
                     tptr_ff   <= '0;
                     state_ff  <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               state_ff <= ST_FETCH;
               if (row_fail) begin
                  r_ff    <= '0;
                  i_ff    <= '0;
                  miss_ff <= '0;
                  tptr_ff <= '0;
                  if (last_x) begin
                     if (last_y) begin
                        found_ff <= 1'b0;
                        state_ff <= ST_DONE;
                     end else begin
                        y_ff      <= y_ff + 1'b1;
                        x_ff      <= '0;
                        yrow_ff   <= yrow_next;
                        pbase_ff  <= yrow_next;
                        rstart_ff <= yrow_next;
                        mptr_ff   <= yrow_next;
                     end
                  end else begin
                     x_ff      <= x_ff + 1'b1;
                     pbase_ff  <= pbase_next_x;
                     rstart_ff <= pbase_next_x;
                     mptr_ff   <= pbase_next_x;
                  end
               end else if (last_pix) begin
                  if (last_row) begin
                     found_ff <= 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     r_ff      <= r_ff + 1'b1;
                     i_ff      <= '0;
                     miss_ff   <= '0;
                     rstart_ff <= rstart_next;
                     mptr_ff   <= rstart_next;
                     tptr_ff   <= tptr_ff + 1'b1;
                  end
               end else begin
                  i_ff    <= i_ff + 1'b1;
                  miss_ff <= miss_next;
                  mptr_ff <= mptr_ff + 1'b1;
                  tptr_ff <= tptr_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign res.valid = (state_ff == ST_DONE);
   assign res.found = found_ff;

endmodule

// File: rtl/core/fuzzy_subimage_search_unit.sv
// Top level of the fuzzy sub-image search unit: register port, result register.
// Depends on fss_pkg and fss_engine.
// Load: one transfer per cycle while no search is running, no result. Search: the divider
// first forms the row mismatch limit, then each compared pixel passes a fetch and a check state.
// Result sits in an output register; loads are taken while it waits.
// Reset: the configuration registers return to their defaults; pixel stores hold no defined value.
module fuzzy_subimage_search_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_index[15:0], pixel_value[23:16]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // found[0], zero fill[7:1]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [fss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DW = fss_pkg::DIM_W;

   fss_pkg::cfg_type    cfg_ff;
   fss_pkg::result_type res;
   logic                res_ready;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [fss_pkg::REG_IDX_W-1:0] reg_idx;
   logic                csr_wr;

   assign reg_idx    = csr_paddr[fss_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.main_width       <= fss_pkg::RST_MAIN_WIDTH;
         cfg_ff.main_height      <= fss_pkg::RST_MAIN_HEIGHT;
         cfg_ff.tmpl_width       <= fss_pkg::RST_TMPL_WIDTH;
         cfg_ff.tmpl_height      <= fss_pkg::RST_TMPL_HEIGHT;
         cfg_ff.tolerance        <= fss_pkg::RST_TOLERANCE;
         cfg_ff.mismatch_divisor <= fss_pkg::RST_DIVISOR;
      end else if (csr_wr) begin
         case (reg_idx)
            fss_pkg::REG_MAIN_WIDTH:  cfg_ff.main_width       <= csr_pwdata[DW-1:0];
            fss_pkg::REG_MAIN_HEIGHT: cfg_ff.main_height      <= csr_pwdata[DW-1:0];
            fss_pkg::REG_TMPL_WIDTH:  cfg_ff.tmpl_width       <= csr_pwdata[DW-1:0];
            fss_pkg::REG_TMPL_HEIGHT: cfg_ff.tmpl_height      <= csr_pwdata[DW-1:0];
            fss_pkg::REG_TOLERANCE:   cfg_ff.tolerance        <= csr_pwdata[DW-1:0];
            fss_pkg::REG_DIVISOR:     cfg_ff.mismatch_divisor <= csr_pwdata[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         fss_pkg::REG_MAIN_WIDTH:  csr_prdata = 32'(cfg_ff.main_width);
         fss_pkg::REG_MAIN_HEIGHT: csr_prdata = 32'(cfg_ff.main_height);
         fss_pkg::REG_TMPL_WIDTH:  csr_prdata = 32'(cfg_ff.tmpl_width);
         fss_pkg::REG_TMPL_HEIGHT: csr_prdata = 32'(cfg_ff.tmpl_height);
         fss_pkg::REG_TOLERANCE:   csr_prdata = 32'(cfg_ff.tolerance);
         fss_pkg::REG_DIVISOR:     csr_prdata = 32'(cfg_ff.mismatch_divisor);
         default:                  csr_prdata = '0;
      endcase
   end

   fss_engine #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_index (req_tdata[15:0]),
      .req_value (req_tdata[23:16]),
      .res       (res),
      .res_ready (res_ready)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && res_ready) begin
         rsp_found_ff <= res.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_found_ff};

endmodule

// File: dv/testbench.sv
// Self-checking testbench for fuzzy_subimage_search_unit, with its own model of the search.
// Depends on fss_pkg and the unit's RTL; drives the request stream and the register port,
// and compares every result transfer against the predicted found flag.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fss_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_DIM       = 256;
   localparam int STORE_SIZE    = 65536;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int REPORT_LIMIT  = 10;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;   // pixel_index[15:0], pixel_value[23:16]
   logic [1:0]            req_tuser;   // op[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // found[0], zero fill[7:1]
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit [PIX_W-1:0] main_image [STORE_SIZE];
   bit [PIX_W-1:0] tmpl_image [STORE_SIZE];
   cfg_type        search_cfg;
   bit             pending_found [$];

   int send_idle_pct;
   int recv_idle_pct;
   int rsp_hold;
   int item_count;
   int load_count;
   int search_count;
   int found_count;
   int unused_count;
   int checked_count;
   int mismatch_count;
   int cycle_count;

   fuzzy_subimage_search_unit DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick(int lo, int hi);
      return int'($urandom_range(hi, lo));
   endfunction

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int clamp_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic int alias_dim(int d);
      return (d == 1 && chance(50)) ? 0 : d;
   endfunction

   function automatic bit compute_found();
      int mw, mh, tw, th, limit, misses, d;
      bit row_ok;
      mw = clamp_dim(search_cfg.main_width);
      mh = clamp_dim(search_cfg.main_height);
      tw = clamp_dim(search_cfg.tmpl_width);
      th = clamp_dim(search_cfg.tmpl_height);
      limit = tw / ((search_cfg.mismatch_divisor == '0) ? 1 : int'(search_cfg.mismatch_divisor));
      if (tw > mw || th > mh) return 1'b0;
      for (int y = 0; y <= mh - th; y++) begin
         for (int x = 0; x <= mw - tw; x++) begin
            row_ok = 1'b1;
            for (int r = 0; r < th && row_ok; r++) begin
               misses = 0;
               for (int c = 0; c < tw; c++) begin
                  d = int'(main_image[((y + r) * mw + x + c) % STORE_SIZE])
                      - int'(tmpl_image[(r * tw + c) % STORE_SIZE]);
                  if (d < 0) d = -d;
                  if (d >= int'(search_cfg.tolerance)) misses++;
               end
               if (misses > limit) row_ok = 1'b0;
            end
            if (row_ok) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic check_result(logic [7:0] data);
      logic [7:0] want;
      checked_count++;
      if (pending_found.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result transfer at cycle %0d: rsp_tdata %h", cycle_count, data);
         return;
      end
      want = {7'b0, pending_found.pop_front()};
      if (data !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("found mismatch at cycle %0d: expected %h, got %h",
                     cycle_count, want, data);
      end
   endtask

   // Receiver: check each transfer, then pick the next ready level.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !chance(recv_idle_pct);
         end
      end
   end

   task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] idx, logic [PIX_W-1:0] val);
      bit hit;
      while (chance(send_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {val, idx};
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_LOAD_MAIN: begin
            main_image[idx] = val;
            load_count++;
         end
         OP_LOAD_TMPL: begin
            tmpl_image[idx] = val;
            load_count++;
         end
         OP_SEARCH: begin
            hit = compute_found();
            pending_found.push_back(hit);
            search_count++;
            found_count += hit;
         end
         default: unused_count++;
      endcase
      if (op != OP_UNUSED) item_count++;
   endtask

   task automatic wait_results(int settle);
      req_tvalid <= 1'b0;
      while (pending_found.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(logic [REG_IDX_W-1:0] index, int value);
      logic [DIM_W-1:0] v;
      v = DIM_W'(value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_MAIN_WIDTH:  search_cfg.main_width       = v;
         REG_MAIN_HEIGHT: search_cfg.main_height      = v;
         REG_TMPL_WIDTH:  search_cfg.tmpl_width       = v;
         REG_TMPL_HEIGHT: search_cfg.tmpl_height      = v;
         REG_TOLERANCE:   search_cfg.tolerance        = v;
         REG_DIVISOR:     search_cfg.mismatch_divisor = v;
         default: ;
      endcase
   endtask

   task automatic write_config(int mw, int mh, int tw, int th, int tol, int dv);
      wait_results(SETTLE_CYCLES);
      write_register(REG_MAIN_WIDTH, mw);
      write_register(REG_MAIN_HEIGHT, mh);
      write_register(REG_TMPL_WIDTH, tw);
      write_register(REG_TMPL_HEIGHT, th);
      write_register(REG_TOLERANCE, tol);
      write_register(REG_DIVISOR, dv);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_search();
      send_item(OP_SEARCH, ADDR_W'(pick(0, 65535)), PIX_W'(pick(0, 255)));
   endtask

   // Occasional unused op or load anywhere in either store.
   task automatic send_stray();
      if (chance(6)) begin
         case (pick(0, 2))
            0:       send_item(OP_UNUSED, ADDR_W'(pick(0, 65535)), PIX_W'(pick(0, 255)));
            1:       send_item(OP_LOAD_MAIN, ADDR_W'(pick(0, 65535)), PIX_W'(pick(0, 255)));
            default: send_item(OP_LOAD_TMPL, ADDR_W'(pick(0, 65535)), PIX_W'(pick(0, 255)));
         endcase
      end
   endtask

   // Fill both images for the current sizes; the template is cut from the main image
   // with small deltas and some outright noise.
   task automatic load_images(int noise_pct);
      int mw, mh, tw, th, px, py, v;
      bit fits;
      mw = clamp_dim(search_cfg.main_width);
      mh = clamp_dim(search_cfg.main_height);
      tw = clamp_dim(search_cfg.tmpl_width);
      th = clamp_dim(search_cfg.tmpl_height);
      fits = (tw <= mw) && (th <= mh);
      for (int i = 0; i < mw * mh; i++) begin
         send_stray();
         send_item(OP_LOAD_MAIN, ADDR_W'(i), PIX_W'(pick(0, 255)));
      end
      px = fits ? pick(0, mw - tw) : 0;
      py = fits ? pick(0, mh - th) : 0;
      for (int r = 0; r < th; r++) begin
         for (int c = 0; c < tw; c++) begin
            if (!fits || chance(noise_pct)) begin
               v = pick(0, 255);
            end else begin
               v = int'(main_image[(py + r) * mw + px + c]) + pick(0, 16) - 8;
               if (v < 0) v = 0;
               if (v > 255) v = 255;
            end
            send_stray();
            send_item(OP_LOAD_TMPL, ADDR_W'(r * tw + c), PIX_W'(v));
         end
      end
   endtask

   task automatic tweak_pixels(int n);
      int mw, mh, tw, th;
      mw = clamp_dim(search_cfg.main_width);
      mh = clamp_dim(search_cfg.main_height);
      tw = clamp_dim(search_cfg.tmpl_width);
      th = clamp_dim(search_cfg.tmpl_height);
      repeat (n) begin
         if (chance(50))
            send_item(OP_LOAD_MAIN, ADDR_W'(pick(0, mw * mh - 1)), PIX_W'(pick(0, 255)));
         else
            send_item(OP_LOAD_TMPL, ADDR_W'(pick(0, tw * th - 1)), PIX_W'(pick(0, 255)));
      end
   endtask

   task automatic test_directed();
      write_config(3, 2, 2, 1, 0, 1);
      send_item(OP_LOAD_MAIN, 16'd0, 8'h00);
      send_item(OP_LOAD_MAIN, 16'd1, 8'hFF);
      send_item(OP_LOAD_MAIN, 16'd2, 8'h55);
      send_item(OP_LOAD_MAIN, 16'd3, 8'hAA);
      send_item(OP_LOAD_MAIN, 16'd4, 8'h10);
      send_item(OP_LOAD_MAIN, 16'd5, 8'h28);
      send_item(OP_LOAD_TMPL, 16'd0, 8'h80);
      send_item(OP_LOAD_TMPL, 16'd1, 8'h7F);
      send_item(OP_LOAD_MAIN, 16'hFFFF, 8'hFF);
      send_item(OP_LOAD_TMPL, 16'hFFFF, 8'h00);
      send_item(OP_UNUSED, 16'hFFFF, 8'hFF);
      send_search();
      write_config(3, 2, 2, 1, 0, 511);
      send_search();
      write_config(3, 2, 2, 1, 511, 0);
      send_search();
      send_item(OP_LOAD_TMPL, 16'd2, 8'h55);
      send_item(OP_LOAD_TMPL, 16'd3, 8'hAA);
      write_config(3, 2, 4, 1, 24, 10);
      send_search();
      write_config(3, 2, 1, 3, 24, 10);
      send_search();
      // tolerance boundary on a single pixel
      send_item(OP_LOAD_TMPL, 16'd0, 8'h18);
      write_config(0, 0, 0, 0, 24, 10);
      send_search();
      write_config(0, 0, 0, 0, 25, 10);
      send_search();
   endtask

   task automatic test_max_width();
      write_config(511, 1, 256, 1, 24, 10);
      load_images(0);
      send_search();
      write_config(511, 1, 256, 300, 24, 10);
      send_search();
   endtask

   // The 256 x 1 images left by the width test read the same as 1 x 256 images.
   task automatic test_max_height();
      int r;
      write_config(1, 400, 0, 256, 100, 2);
      send_search();
      r = pick(0, 255);
      send_item(OP_LOAD_TMPL, ADDR_W'(r), main_image[r] ^ 8'h80);
      send_search();
   endtask

   task automatic test_backpressure();
      write_config(6, 4, 2, 2, 30, 4);
      load_images(10);
      rsp_hold = 400;
      repeat (6) begin
         send_search();
         tweak_pixels(2);
      end
      wait_results(1);
      repeat (3) begin
         send_search();
         tweak_pixels(1);
      end
   endtask

   task automatic run_scene();
      int mw, mh, tw, th, tol, dv;
      mw = pick(1, 10);
      mh = pick(1, 8);
      tw = pick(1, (mw < 5) ? mw : 5);
      th = pick(1, (mh < 4) ? mh : 4);
      if (chance(10)) begin
         if (chance(50)) tw = mw + pick(1, 3);
         else th = mh + pick(1, 3);
      end
      case (pick(0, 7))
         0:       tol = 0;
         1:       tol = pick(256, 511);
         2:       tol = 255;
         default: tol = pick(1, 64);
      endcase
      case (pick(0, 5))
         0:       dv = 0;
         1:       dv = 1;
         2:       dv = pick(100, 511);
         default: dv = pick(2, 12);
      endcase
      write_config(alias_dim(mw), alias_dim(mh), alias_dim(tw), alias_dim(th), tol, dv);
      load_images(pick(0, 25));
      repeat (pick(1, 3)) begin
         send_search();
         tweak_pixels(pick(0, 3));
      end
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
      int start;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = item_count;
      while (item_count - start < n_items) run_scene();
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      search_cfg = '{RST_MAIN_WIDTH, RST_MAIN_HEIGHT, RST_TMPL_WIDTH,
                     RST_TMPL_HEIGHT, RST_TOLERANCE, RST_DIVISOR};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_max_width();
      test_max_height();
      test_backpressure();
      test_random_traffic(6, 81, 30);
      test_random_traffic(81, 6, 30);
      test_random_traffic(0, 0, 30);

      wait_results(50);
      $display("Covered %0d pixel loads, %0d searches (%0d found), %0d unused-op transfers.",
               load_count, search_count, found_count, unused_count);
      $display("Checked %0d result transfers over %0d cycles, %0d mismatches.",
               checked_count, cycle_count, mismatch_count);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/fss_pkg.sv
rtl/core/fss_divider.sv
rtl/core/fss_engine.sv
rtl/core/fuzzy_subimage_search_unit.sv
dv/testbench.sv
